// ===== rtl/wrr_pkg.sv =====
package wrr_pkg;

    localparam int NUM_CLASSES  = 4;
    localparam int QUEUE_DEPTH  = 16;
    localparam int CMDQ_DEPTH   = 2;
    localparam int RESQ_DEPTH   = 2;

    localparam int DATA_W       = 32;
    localparam int FUNC_W       = 2;
    localparam int SEL_W        = 2;
    localparam int STATUS_W     = 2;
    localparam int WEIGHT_W     = 8;
    localparam int CFG_IDX_W    = 2;
    localparam int RUN_W        = WEIGHT_W;

    localparam int CLASS_W      = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int PTR_W        = $clog2(QUEUE_DEPTH);
    localparam int CNT_W        = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH    = NUM_CLASSES * QUEUE_DEPTH;
    localparam int ADDR_W       = $clog2(MEM_DEPTH);

    localparam int CQ_PTR_W     = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CQ_CNT_W     = $clog2(CMDQ_DEPTH + 1);
    localparam int RQ_PTR_W     = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
    localparam int RQ_CNT_W     = $clog2(RESQ_DEPTH + 1);

    // Operation codes on the func field.
    localparam logic [FUNC_W-1:0] FUNC_PUSH = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP  = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_PEEK = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_DROP  = 2'd2;

    typedef enum logic [1:0] {
        OP_PUSH,
        OP_POP,
        OP_PEEK,
        OP_NONE
    } t_op;

    typedef enum logic {
        BK_TAKE,
        BK_REPLY
    } t_back_state;

    typedef struct packed {
        t_op                        op;
        logic                       sel_ok;
        logic [CLASS_W-1:0]         cls;
        logic signed [DATA_W-1:0]   data;
    } t_cmd;

    typedef struct packed {
        logic signed [DATA_W-1:0]   data;
        logic [STATUS_W-1:0]        status;
        logic [SEL_W-1:0]           cls;
    } t_res;

    // A weight of zero serves as a weight of one.
    function automatic logic [WEIGHT_W-1:0] eff_weight(input logic [WEIGHT_W-1:0] w);
        return (w == '0) ? WEIGHT_W'(1) : w;
    endfunction

    function automatic logic [CLASS_W-1:0] next_class(input logic [CLASS_W-1:0] c);
        return (int'(c) + 1 >= NUM_CLASSES) ? '0 : c + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
        return (int'(p) + 1 >= QUEUE_DEPTH) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [ADDR_W-1:0] mem_addr(input logic [CLASS_W-1:0] c,
                                                   input logic [PTR_W-1:0]   p);
        return ADDR_W'(c) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(p);
    endfunction

endpackage

// ===== rtl/weighted_round_robin_queue.sv =====
// Channel   Direction  Handshake                    Payload
// request   in         push / full                  i_func, i_data_in, i_class_sel
// result    out        empty / pop                  o_data_out, o_status, o_served_class
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// The front takes one request beat per cycle, while it is not full, into a two-entry command queue.
// The back handles each request in a take state, which settles the class and accesses
// the queue memory, and a reply state, which hands the result to a two-entry result
// queue and holds while that queue is full; the outputs show the registered queue head.
// Reset clears pointers, fill counts, the class rotation and sets all weights to one;
// the queue memory is not cleared. A stalled result side backs up and raises full.
module weighted_round_robin_queue (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                push,
    output logic                                full,
    input  logic [wrr_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [wrr_pkg::DATA_W-1:0]   i_data_in,
    input  logic [wrr_pkg::SEL_W-1:0]           i_class_sel,
    output logic                                empty,
    input  logic                                pop,
    output logic signed [wrr_pkg::DATA_W-1:0]   o_data_out,
    output logic [wrr_pkg::STATUS_W-1:0]        o_status,
    output logic [wrr_pkg::SEL_W-1:0]           o_served_class,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [wrr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wrr_pkg::WEIGHT_W-1:0]        i_cfg_data
);

    logic               cmd_valid;
    wrr_pkg::t_cmd      cmd;
    logic               cmd_take;
    logic               res_valid;
    wrr_pkg::t_res      res;
    logic               resq_full;
    wrr_pkg::t_res      res_out;

    assign o_cfg_ready = 1'b1;

    wrr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_func      (i_func),
        .i_data_in   (i_data_in),
        .i_class_sel (i_class_sel),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd),
        .i_take      (cmd_take)
    );

    wrr_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_cmd_take  (cmd_take),
        .i_res_room  (!resq_full),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    wrr_resq u_resq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_valid),
        .i_res   (res),
        .o_full  (resq_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_res   (res_out)
    );

    assign o_data_out     = res_out.data;
    assign o_status       = res_out.status;
    assign o_served_class = res_out.cls;

endmodule

// ===== rtl/wrr_front.sv =====
module wrr_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    output logic                                o_full,
    input  logic [wrr_pkg::FUNC_W-1:0]          i_func,
    input  logic signed [wrr_pkg::DATA_W-1:0]   i_data_in,
    input  logic [wrr_pkg::SEL_W-1:0]           i_class_sel,
    output logic                                o_cmd_valid,
    output wrr_pkg::t_cmd                       o_cmd,
    input  logic                                i_take
);

    wrr_pkg::t_cmd                       cmd_in;
    wrr_pkg::t_cmd                       r_slot [wrr_pkg::CMDQ_DEPTH];
    logic [wrr_pkg::CQ_PTR_W-1:0]        r_wr_ptr;
    logic [wrr_pkg::CQ_PTR_W-1:0]        r_rd_ptr;
    logic [wrr_pkg::CQ_CNT_W-1:0]        r_count;
    logic [wrr_pkg::CQ_CNT_W-1:0]        n_count;
    logic                                wr_en;
    logic                                rd_en;

    // Decode the operation and check the class once, on the way in.
    always_comb begin
        unique case (i_func)
            wrr_pkg::FUNC_PUSH: cmd_in.op = wrr_pkg::OP_PUSH;
            wrr_pkg::FUNC_POP:  cmd_in.op = wrr_pkg::OP_POP;
            wrr_pkg::FUNC_PEEK: cmd_in.op = wrr_pkg::OP_PEEK;
            wrr_pkg::FUNC_NONE: cmd_in.op = wrr_pkg::OP_NONE;
        endcase
        cmd_in.sel_ok = int'(i_class_sel) < wrr_pkg::NUM_CLASSES;
        cmd_in.cls    = wrr_pkg::CLASS_W'(i_class_sel);
        cmd_in.data   = i_data_in;
    end

    assign o_full      = (int'(r_count) == wrr_pkg::CMDQ_DEPTH);
    assign o_cmd_valid = (r_count != '0);
    assign o_cmd       = r_slot[r_rd_ptr];
    assign wr_en       = i_push && !o_full;
    assign rd_en       = i_take && o_cmd_valid;

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= (int'(r_wr_ptr) + 1 >= wrr_pkg::CMDQ_DEPTH) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (int'(r_rd_ptr) + 1 >= wrr_pkg::CMDQ_DEPTH) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= cmd_in;
        end
    end

endmodule

// ===== rtl/wrr_back.sv =====
module wrr_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wrr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wrr_pkg::WEIGHT_W-1:0]        i_cfg_data,
    input  logic                                i_cmd_valid,
    input  wrr_pkg::t_cmd                       i_cmd,
    output logic                                o_cmd_take,
    input  logic                                i_res_room,
    output logic                                o_res_valid,
    output wrr_pkg::t_res                       o_res
);

    localparam int N = wrr_pkg::NUM_CLASSES;

    wrr_pkg::t_back_state                r_state;
    wrr_pkg::t_back_state                n_state;

    logic [wrr_pkg::WEIGHT_W-1:0]        r_weight [N];
    logic [wrr_pkg::PTR_W-1:0]           r_head   [N];
    logic [wrr_pkg::PTR_W-1:0]           r_tail   [N];
    logic [wrr_pkg::CNT_W-1:0]           r_fill   [N];
    logic [wrr_pkg::CLASS_W-1:0]         r_cur;
    logic [wrr_pkg::RUN_W-1:0]           r_run;

    logic [wrr_pkg::DATA_W-1:0]          mem [wrr_pkg::MEM_DEPTH];
    logic [wrr_pkg::DATA_W-1:0]          r_rd_data;
    logic                                r_rd_used;
    logic [wrr_pkg::STATUS_W-1:0]        r_status;
    logic [wrr_pkg::CLASS_W-1:0]         r_cls;

    logic [N-1:0]                        nz;
    logic [N-1:0]                        run_lt;
    logic [N-1:0]                        run1_ge;
    logic                                any_nz;
    logic                                stay;
    logic [wrr_pkg::CLASS_W-1:0]         scan_cls;
    logic [wrr_pkg::CLASS_W-1:0]         sel_cls;
    logic [wrr_pkg::RUN_W-1:0]           sel_run;
    logic [wrr_pkg::RUN_W:0]             run1;
    logic                                push_ok;
    logic                                mem_we;
    logic                                mem_re;
    logic [wrr_pkg::ADDR_W-1:0]          wr_addr;
    logic [wrr_pkg::ADDR_W-1:0]          rd_addr;

    // Per-class status bits; every weight is compared at its own place.
    always_comb begin
        for (int i = 0; i < N; i++) begin
            nz[i]      = (r_fill[i] != '0);
            run_lt[i]  = r_run < wrr_pkg::eff_weight(r_weight[i]);
            run1_ge[i] = run1 >= {1'b0, wrr_pkg::eff_weight(r_weight[i])};
        end
    end

    assign any_nz = |nz;
    assign stay   = nz[r_cur] && run_lt[r_cur];

    // Search the following classes in ring order for the first one holding data.
    // The current class itself comes last, with a fresh run.
    always_comb begin
        int  idx;
        logic found;
        scan_cls = r_cur;
        found    = 1'b0;
        for (int k = 1; k <= N; k++) begin
            idx = int'(r_cur) + k;
            if (idx >= N) begin
                idx = idx - N;
            end
            if (!found && nz[wrr_pkg::CLASS_W'(idx)]) begin
                found    = 1'b1;
                scan_cls = wrr_pkg::CLASS_W'(idx);
            end
        end
    end

    assign sel_cls = stay ? r_cur : scan_cls;
    assign sel_run = stay ? r_run : '0;
    assign run1    = {1'b0, sel_run} + 1'b1;

    assign push_ok = i_cmd.sel_ok && (int'(r_fill[i_cmd.cls]) < wrr_pkg::QUEUE_DEPTH);
    assign wr_addr = wrr_pkg::mem_addr(i_cmd.cls, r_tail[i_cmd.cls]);
    assign rd_addr = wrr_pkg::mem_addr(sel_cls, r_head[sel_cls]);
    assign mem_we  = o_cmd_take && (i_cmd.op == wrr_pkg::OP_PUSH) && push_ok;
    assign mem_re  = o_cmd_take && any_nz &&
                     (i_cmd.op == wrr_pkg::OP_POP || i_cmd.op == wrr_pkg::OP_PEEK);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            wrr_pkg::BK_TAKE: begin
                if (i_cmd_valid) begin
                    n_state = wrr_pkg::BK_REPLY;
                end
            end
            wrr_pkg::BK_REPLY: begin
                if (i_res_room) begin
                    n_state = wrr_pkg::BK_TAKE;
                end
            end
        endcase
    end

    always_comb begin
        o_cmd_take  = (r_state == wrr_pkg::BK_TAKE) && i_cmd_valid;
        o_res_valid = (r_state == wrr_pkg::BK_REPLY) && i_res_room;
        o_res.data  = r_rd_used ? r_rd_data : '0;
        o_res.status = r_status;
        o_res.cls   = wrr_pkg::SEL_W'(r_cls);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wrr_pkg::BK_TAKE;
            r_cur   <= '0;
            r_run   <= '0;
            for (int i = 0; i < N; i++) begin
                r_weight[i] <= wrr_pkg::WEIGHT_W'(1);
                r_head[i]   <= '0;
                r_tail[i]   <= '0;
                r_fill[i]   <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we && int'(i_cfg_index) < N) begin
                r_weight[wrr_pkg::CLASS_W'(i_cfg_index)] <= i_cfg_data;
            end
            if (mem_we) begin
                r_tail[i_cmd.cls] <= wrr_pkg::next_ptr(r_tail[i_cmd.cls]);
                r_fill[i_cmd.cls] <= r_fill[i_cmd.cls] + 1'b1;
            end
            if (mem_re) begin
                if (i_cmd.op == wrr_pkg::OP_POP) begin
                    r_head[sel_cls] <= wrr_pkg::next_ptr(r_head[sel_cls]);
                    r_fill[sel_cls] <= r_fill[sel_cls] - 1'b1;
                    if (run1_ge[sel_cls]) begin
                        r_cur <= wrr_pkg::next_class(sel_cls);
                        r_run <= '0;
                    end else begin
                        r_cur <= sel_cls;
                        r_run <= run1[wrr_pkg::RUN_W-1:0];
                    end
                end else begin
                    // A peek settles on the class but serves nothing.
                    r_cur <= sel_cls;
                    r_run <= sel_run;
                end
            end
        end
    end

    // Result fields of the beat taken; they wait here until the reply.
    always_ff @(posedge i_clk) begin
        if (o_cmd_take) begin
            r_rd_used <= mem_re;
            r_cls     <= mem_re ? sel_cls : '0;
            priority if (i_cmd.op == wrr_pkg::OP_PUSH) begin
                r_status <= push_ok ? wrr_pkg::STATUS_OK : wrr_pkg::STATUS_DROP;
            end else if (i_cmd.op == wrr_pkg::OP_NONE) begin
                r_status <= wrr_pkg::STATUS_OK;
            end else begin
                r_status <= any_nz ? wrr_pkg::STATUS_OK : wrr_pkg::STATUS_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= i_cmd.data;
        end
        if (mem_re) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    a_take_then_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> r_state == wrr_pkg::BK_REPLY)
        else $error("command taken but no reply pending");

    a_run_below_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run != {wrr_pkg::RUN_W{1'b1}})
        else $error("served run reached its ceiling");

    a_cur_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_cur) < N)
        else $error("current class out of range");

    a_empty_means_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.status == wrr_pkg::STATUS_EMPTY) |-> !any_nz)
        else $error("empty reported while a class holds data");

endmodule

// ===== rtl/wrr_resq.sv =====
module wrr_resq (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  wrr_pkg::t_res           i_res,
    output logic                    o_full,
    input  logic                    i_pop,
    output logic                    o_empty,
    output wrr_pkg::t_res           o_res
);

    wrr_pkg::t_res                   r_slot [wrr_pkg::RESQ_DEPTH];
    logic [wrr_pkg::RQ_PTR_W-1:0]    r_wr_ptr;
    logic [wrr_pkg::RQ_PTR_W-1:0]    r_rd_ptr;
    logic [wrr_pkg::RQ_CNT_W-1:0]    r_count;
    logic [wrr_pkg::RQ_CNT_W-1:0]    n_count;
    logic                            wr_en;
    logic                            rd_en;

    assign o_full  = (int'(r_count) == wrr_pkg::RESQ_DEPTH);
    assign o_empty = (r_count == '0);
    assign o_res   = r_slot[r_rd_ptr];
    assign wr_en   = i_push && !o_full;
    assign rd_en   = i_pop && !o_empty;

    always_comb begin
        n_count = r_count;
        if (wr_en && !rd_en) begin
            n_count = r_count + 1'b1;
        end else if (rd_en && !wr_en) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (wr_en) begin
                r_wr_ptr <= (int'(r_wr_ptr) + 1 >= wrr_pkg::RESQ_DEPTH) ? '0 : r_wr_ptr + 1'b1;
            end
            if (rd_en) begin
                r_rd_ptr <= (int'(r_rd_ptr) + 1 >= wrr_pkg::RESQ_DEPTH) ? '0 : r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_slot[r_wr_ptr] <= i_res;
        end
    end

endmodule

// ===== dv/tb_weighted_round_robin_queue.sv =====
`timescale 1ns / 100ps

module tb_weighted_round_robin_queue;

    typedef struct {
        logic [wrr_pkg::FUNC_W-1:0]        func;
        logic signed [wrr_pkg::DATA_W-1:0] data;
        logic [wrr_pkg::SEL_W-1:0]         sel;
    } t_queue_op;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int PHASE_ITEMS     = 155;

    logic                                i_clk          = 1'b0;
    logic                                i_rst_n        = 1'b0;
    logic                                push           = 1'b0;
    logic                                full;
    logic [wrr_pkg::FUNC_W-1:0]          i_func         = wrr_pkg::FUNC_NONE;
    logic signed [wrr_pkg::DATA_W-1:0]   i_data_in      = '0;
    logic [wrr_pkg::SEL_W-1:0]           i_class_sel    = '0;
    logic                                empty;
    logic                                pop            = 1'b0;
    logic signed [wrr_pkg::DATA_W-1:0]   o_data_out;
    logic [wrr_pkg::STATUS_W-1:0]        o_status;
    logic [wrr_pkg::SEL_W-1:0]           o_served_class;
    logic                                i_cfg_valid    = 1'b0;
    logic                                o_cfg_ready;
    logic [wrr_pkg::CFG_IDX_W-1:0]       i_cfg_index    = '0;
    logic [wrr_pkg::WEIGHT_W-1:0]        i_cfg_data     = '0;

    // Scoreboard side: a private copy of the class queues and the rotation.
    logic signed [wrr_pkg::DATA_W-1:0]
        class_store [wrr_pkg::NUM_CLASSES][wrr_pkg::QUEUE_DEPTH];
    logic [wrr_pkg::PTR_W-1:0]           class_head  [wrr_pkg::NUM_CLASSES];
    logic [wrr_pkg::PTR_W-1:0]           class_tail  [wrr_pkg::NUM_CLASSES];
    logic [wrr_pkg::CNT_W-1:0]           class_fill  [wrr_pkg::NUM_CLASSES];
    logic [wrr_pkg::WEIGHT_W-1:0]        class_weight[wrr_pkg::NUM_CLASSES];
    logic [wrr_pkg::CLASS_W-1:0]         rr_class;
    logic [wrr_pkg::RUN_W-1:0]           rr_run;

    t_queue_op                  pending_ops[$];
    wrr_pkg::t_res              expected_replies[$];
    t_queue_op                  next_op;
    wrr_pkg::t_res              want;
    int                         errors     = 0;
    int                         hold_req   = 0;
    int                         hold_ack   = 0;
    int                         hold_left  = 0;
    bit                         no_idle    = 1'b0;

    weighted_round_robin_queue dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .push           (push),
        .full           (full),
        .i_func         (i_func),
        .i_data_in      (i_data_in),
        .i_class_sel    (i_class_sel),
        .empty          (empty),
        .pop            (pop),
        .o_data_out     (o_data_out),
        .o_status       (o_status),
        .o_served_class (o_served_class),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [wrr_pkg::RUN_W-1:0] run_limit(
        input logic [wrr_pkg::CLASS_W-1:0] c);
        return (class_weight[c] == '0) ? wrr_pkg::RUN_W'(1) :
                                         wrr_pkg::RUN_W'(class_weight[c]);
    endfunction

    function automatic void rotate_class();
        rr_class = (int'(rr_class) + 1 >= wrr_pkg::NUM_CLASSES) ? '0 : rr_class + 1'b1;
        rr_run   = '0;
    endfunction

    function automatic wrr_pkg::t_res serve_request(
        input logic [wrr_pkg::FUNC_W-1:0]        func,
        input logic signed [wrr_pkg::DATA_W-1:0] data,
        input logic [wrr_pkg::SEL_W-1:0]         sel);
        wrr_pkg::t_res               r;
        logic [wrr_pkg::CLASS_W-1:0] c;
        bit                          any_full;
        bit                          settled;
        r = '0;
        case (func)
            wrr_pkg::FUNC_PUSH: begin
                if (int'(sel) >= wrr_pkg::NUM_CLASSES ||
                    int'(class_fill[sel]) >= wrr_pkg::QUEUE_DEPTH) begin
                    r.status = wrr_pkg::STATUS_DROP;
                end else begin
                    class_store[sel][class_tail[sel]] = data;
                    class_tail[sel] = (int'(class_tail[sel]) + 1 >= wrr_pkg::QUEUE_DEPTH) ?
                                      '0 : class_tail[sel] + 1'b1;
                    class_fill[sel] = class_fill[sel] + 1'b1;
                end
            end
            wrr_pkg::FUNC_POP, wrr_pkg::FUNC_PEEK: begin
                any_full = 1'b0;
                for (int i = 0; i < wrr_pkg::NUM_CLASSES; i++)
                    if (class_fill[i] != '0) any_full = 1'b1;
                if (!any_full) begin
                    r.status = wrr_pkg::STATUS_EMPTY;
                end else begin
                    // Skip empty classes and classes whose run is used up; a run
                    // above a freshly lowered weight also counts as used up.
                    settled = 1'b0;
                    for (int k = 0; k <= wrr_pkg::NUM_CLASSES; k++) begin
                        if (!settled) begin
                            if (class_fill[rr_class] != '0 && rr_run < run_limit(rr_class))
                                settled = 1'b1;
                            else
                                rotate_class();
                        end
                    end
                    c      = rr_class;
                    r.data = class_store[c][class_head[c]];
                    r.cls  = wrr_pkg::SEL_W'(c);
                    if (func == wrr_pkg::FUNC_POP) begin
                        class_head[c] = (int'(class_head[c]) + 1 >= wrr_pkg::QUEUE_DEPTH) ?
                                        '0 : class_head[c] + 1'b1;
                        class_fill[c] = class_fill[c] - 1'b1;
                        rr_run        = rr_run + 1'b1;
                        if (rr_run >= run_limit(c)) rotate_class();
                    end
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // Request driver: offers queued operations, holding each until accepted.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full)
                expected_replies.push_back(serve_request(i_func, i_data_in, i_class_sel));
            if (!push || !full) begin
                if (pending_ops.size() != 0 && (no_idle || $urandom_range(99) >= 19)) begin
                    next_op = pending_ops.pop_front();
                    i_func      <= next_op.func;
                    i_data_in   <= next_op.data;
                    i_class_sel <= next_op.sel;
                    push        <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // Result monitor: pops at random, with a long hold-off when the test requests one.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop       <= 1'b0;
            hold_left <= 0;
        end else begin
            if (pop && !empty) begin
                if (expected_replies.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected beat: expected none, got %0d/%0d/%0d",
                             $time, o_data_out, o_status, o_served_class);
                end else begin
                    want = expected_replies.pop_front();
                    if (o_data_out !== want.data || o_status !== want.status ||
                        o_served_class !== want.cls) begin
                        errors++;
                        $display("%0t: mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                 $time, want.data, want.status, want.cls,
                                 o_data_out, o_status, o_served_class);
                    end
                end
            end
            if (hold_req != hold_ack) begin
                hold_ack  <= hold_req;
                hold_left <= HOLD_OFF_CYCLES;
                pop       <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                pop       <= 1'b0;
            end else begin
                pop <= no_idle || $urandom_range(99) >= 19;
            end
        end
    end

    task automatic queue_op(input logic [wrr_pkg::FUNC_W-1:0] func,
                            input logic [wrr_pkg::DATA_W-1:0] data,
                            input logic [wrr_pkg::SEL_W-1:0]  sel);
        t_queue_op op;
        op.func = func;
        op.data = data;
        op.sel  = sel;
        pending_ops.push_back(op);
    endtask

    task automatic wait_idle();
        while (pending_ops.size() != 0 || push || expected_replies.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_weight(input int idx, input logic [wrr_pkg::WEIGHT_W-1:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= wrr_pkg::CFG_IDX_W'(idx);
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        class_weight[idx] = value;
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_random_op(input int push_pct);
        int pick;
        pick = $urandom_range(99);
        if (pick < push_pct) begin
            queue_op(wrr_pkg::FUNC_PUSH, $urandom(),
                     wrr_pkg::SEL_W'($urandom_range(wrr_pkg::NUM_CLASSES - 1)));
        end else begin
            pick = $urandom_range(99);
            if (pick < 72)
                queue_op(wrr_pkg::FUNC_POP, $urandom(), wrr_pkg::SEL_W'($urandom()));
            else if (pick < 94)
                queue_op(wrr_pkg::FUNC_PEEK, $urandom(), wrr_pkg::SEL_W'($urandom()));
            else
                queue_op(wrr_pkg::FUNC_NONE, $urandom(), wrr_pkg::SEL_W'($urandom()));
        end
    endtask

    initial begin
        int push_pct;
        int mode;
        int hot_class;
        logic [wrr_pkg::WEIGHT_W-1:0] w;

        for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
            class_head[c]   = '0;
            class_tail[c]   = '0;
            class_fill[c]   = '0;
            class_weight[c] = wrr_pkg::WEIGHT_W'(1);
        end
        rr_class = '0;
        rr_run   = '0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Empty pops and peeks, the idle code, then data extremes in every class.
        queue_op(wrr_pkg::FUNC_POP,  32'h0, 2'd0);
        queue_op(wrr_pkg::FUNC_PEEK, 32'h0, 2'd0);
        queue_op(wrr_pkg::FUNC_NONE, 32'hFFFF_FFFF, 2'd3);
        queue_op(wrr_pkg::FUNC_PUSH, 32'h7FFF_FFFF, 2'd0);
        queue_op(wrr_pkg::FUNC_PUSH, 32'h8000_0000, 2'd1);
        queue_op(wrr_pkg::FUNC_PUSH, 32'h0000_0000, 2'd2);
        queue_op(wrr_pkg::FUNC_PUSH, 32'hFFFF_FFFF, 2'd3);
        queue_op(wrr_pkg::FUNC_PEEK, 32'h0, 2'd0);
        queue_op(wrr_pkg::FUNC_POP,  32'h0, 2'd0);
        queue_op(wrr_pkg::FUNC_PEEK, 32'h0, 2'd0);
        for (int i = 0; i < 3; i++) queue_op(wrr_pkg::FUNC_POP, 32'h0, 2'd0);
        queue_op(wrr_pkg::FUNC_POP,  32'h0, 2'd0);
        wait_idle();

        // Zero weights act as one; then lower class 0's weight below its current run.
        write_weight(0, 8'd5);
        write_weight(1, 8'd0);
        write_weight(2, 8'd0);
        write_weight(3, 8'd255);
        for (int i = 0; i < 6; i++) queue_op(wrr_pkg::FUNC_PUSH, $urandom(), 2'd0);
        for (int i = 0; i < 3; i++) queue_op(wrr_pkg::FUNC_POP, 32'h0, 2'd0);
        wait_idle();
        write_weight(0, 8'd2);
        queue_op(wrr_pkg::FUNC_PUSH, $urandom(), 2'd1);
        queue_op(wrr_pkg::FUNC_PUSH, $urandom(), 2'd1);
        for (int i = 0; i < 3; i++) queue_op(wrr_pkg::FUNC_POP, 32'h0, 2'd0);
        queue_op(wrr_pkg::FUNC_PEEK, 32'h0, 2'd0);
        wait_idle();

        for (int phase = 0; phase < 12; phase++) begin
            mode = phase % 5;
            for (int c = 0; c < wrr_pkg::NUM_CLASSES; c++) begin
                case (mode)
                    0: w = 8'd255;
                    1: w = 8'd0;
                    2: w = wrr_pkg::WEIGHT_W'($urandom());
                    3: w = wrr_pkg::WEIGHT_W'($urandom_range(3, 1));
                    default: w = ($urandom_range(1) != 0) ? 8'd255 : 8'd1;
                endcase
                write_weight(c, w);
            end
            no_idle <= (phase == 6);
            case (phase % 3)
                0: push_pct = 50;
                1: push_pct = 75;
                default: push_pct = 25;
            endcase

            if (phase == 3) begin
                // Results back up during the hold-off while one class overflows.
                @(posedge i_clk);
                hold_req <= hold_req + 1;
                hot_class = $urandom_range(wrr_pkg::NUM_CLASSES - 1);
                for (int i = 0; i < 40; i++) begin
                    if (i % 5 == 4)
                        queue_random_op(0);
                    else
                        queue_op(wrr_pkg::FUNC_PUSH, $urandom(), wrr_pkg::SEL_W'(hot_class));
                end
            end

            for (int i = 0; i < PHASE_ITEMS; i++) queue_random_op(push_pct);
            wait_idle();
        end
        no_idle <= 1'b0;

        wait_idle();
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("tb_weighted_round_robin_queue OK");
        else
            $display("tb_weighted_round_robin_queue NOT OK");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_weighted_round_robin_queue NOT OK");
        $finish;
    end

endmodule
